// File: hw/rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the binary/bcd converter
// stage record handed from cell to cell, digit count, decimal limit
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned NumCells = 8;
  localparam int unsigned NibW     = 4;
  localparam int unsigned WordW    = 32;
  localparam int unsigned SumW     = 28;

  localparam logic [WordW-1:0] DecLimit = 32'd100000000;
  localparam logic [NibW-1:0]  MaxDigit = 4'd9;

  // operation codes
  localparam logic OpToBcd = 1'b0;
  localparam logic OpToBin = 1'b1;

  // state carried along the cell chain
  typedef struct packed {
    logic             op;
    logic             ovf;
    logic             bad;
    logic [WordW-1:0] bin_rest;
    logic [WordW-1:0] bcd_rest;
    logic [WordW-1:0] digits;
    logic [SumW-1:0]  sum;
  } stage_t;

  // true when every nibble of a packed word is a decimal digit
  function automatic logic all_digits_valid(logic [WordW-1:0] w);
    logic ok;
    ok = 1'b1;
    for (int d = 0; d < NumCells; d++) begin
      if (w[NibW*d +: NibW] > MaxDigit) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// File: hw/rtl/bbc_if.sv
// ----------------------------------------------------------------------------
// bbc_if: valid/ready channels of the binary/bcd converter
// request channel (operation and both operands) and result channel
// ----------------------------------------------------------------------------
interface bbc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] binary_in;
  logic [31:0] bcd_in;

  modport source (output valid, output operation, output binary_in, output bcd_in,
                  input ready);
  modport sink   (input valid, input operation, input binary_in, input bcd_in,
                  output ready);
endinterface

interface bbc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] bcd_out;
  logic [27:0] binary_out;
  logic        overflow;
  logic        invalid_digit;

  modport source (output valid, output bcd_out, output binary_out, output overflow,
                  output invalid_digit, input ready);
  modport sink   (input valid, input bcd_out, input binary_out, input overflow,
                  input invalid_digit, output ready);
endinterface

// File: hw/rtl/bbc_cell.sv
// ----------------------------------------------------------------------------
// bbc_cell: one cell of the conversion chain
// takes one nibble of each operand: four double-dabble shifts for binary to
// bcd, one multiply-by-ten-and-add for bcd to binary; registered output
// ----------------------------------------------------------------------------
module bbc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bbc_pkg::stage_t stage_i,
  output logic            valid_o,
  input  logic            ready_i,
  output bbc_pkg::stage_t stage_o
);
  import bbc_pkg::*;

  logic   valid_d, valid_q;
  stage_t stage_d, stage_q;

  // one nibble of work on both conversions
  function automatic stage_t cell_step(stage_t s);
    stage_t           r;
    logic [NibW-1:0]  bin_nib;
    logic [NibW-1:0]  bcd_nib;
    logic [WordW-1:0] dig;
    r       = s;
    bin_nib = s.bin_rest[WordW-1 -: NibW];
    bcd_nib = s.bcd_rest[WordW-1 -: NibW];
    dig     = s.digits;
    // double dabble, carries out of the top digit drop off (modulo 10^8)
    for (int b = 0; b < NibW; b++) begin
      for (int d = 0; d < NumCells; d++) begin
        if (dig[NibW*d +: NibW] >= 4'd5) begin
          dig[NibW*d +: NibW] = NibW'(dig[NibW*d +: NibW] + 4'd3);
        end
      end
      dig = {dig[WordW-2:0], bin_nib[NibW-1-b]};
    end
    r.digits   = dig;
    r.bin_rest = {s.bin_rest[WordW-NibW-1:0], {NibW{1'b0}}};
    // horner step: sum * 10 + nibble, nibbles above nine weighted as well
    r.sum      = (s.sum << 3) + (s.sum << 1) + {{(SumW-NibW){1'b0}}, bcd_nib};
    r.bad      = s.bad | (bcd_nib > MaxDigit);
    r.bcd_rest = {s.bcd_rest[WordW-NibW-1:0], {NibW{1'b0}}};
    return r;
  endfunction

  // take a word when empty or when the neighbour takes ours
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = ready_o ? valid_i : valid_q;
    stage_d = cell_step(stage_i);
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// File: hw/rtl/binary_bcd_converter_8digit.sv
// ----------------------------------------------------------------------------
// binary_bcd_converter_8digit: eight-digit binary/bcd converter
// binary to packed bcd (modulo 10^8, with overflow) or packed bcd to binary
// (weighted sum, with invalid-digit flag), chosen per word
//
//   channel | dir | fields
//   in_i    | in  | operation, binary_in, bcd_in
//   out_o   | out | bcd_out, binary_out, overflow, invalid_digit
//
// one word per cycle sustained while the result side keeps taking words; each
// cell of the chain registers the word and takes one nibble of the operand
// reset clears the valid bit of every cell; payload registers are not reset
// ready ripples back through the chain, so empty cells fill while the
// result in the last cell waits to be taken
// ----------------------------------------------------------------------------
module binary_bcd_converter_8digit (
  input  logic          clk_i,
  input  logic          rst_ni,
  bbc_in_if.sink        in_i,
  bbc_out_if.source     out_o
);
  import bbc_pkg::*;

  logic   [NumCells:0] valid_c;
  logic   [NumCells:0] ready_c;
  stage_t              stage_c [NumCells+1];

  // entry record, overflow compared up front
  always_comb begin
    stage_c[0].op       = in_i.operation;
    stage_c[0].ovf      = (in_i.binary_in >= DecLimit);
    stage_c[0].bad      = 1'b0;
    stage_c[0].bin_rest = in_i.binary_in;
    stage_c[0].bcd_rest = in_i.bcd_in;
    stage_c[0].digits   = '0;
    stage_c[0].sum      = '0;
  end

  assign valid_c[0] = in_i.valid;
  assign in_i.ready = ready_c[0];

  // chain of cells
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    bbc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[k]),
      .ready_o (ready_c[k]),
      .stage_i (stage_c[k]),
      .valid_o (valid_c[k+1]),
      .ready_i (ready_c[k+1]),
      .stage_o (stage_c[k+1])
    );
  end

  // result word, fields of the other operation read as zero
  assign ready_c[NumCells]   = out_o.ready;
  assign out_o.valid         = valid_c[NumCells];
  assign out_o.bcd_out       = (stage_c[NumCells].op == OpToBcd) ? stage_c[NumCells].digits : '0;
  assign out_o.overflow      = (stage_c[NumCells].op == OpToBcd) && stage_c[NumCells].ovf;
  assign out_o.binary_out    = (stage_c[NumCells].op == OpToBin) ? stage_c[NumCells].sum : '0;
  assign out_o.invalid_digit = (stage_c[NumCells].op == OpToBin) && stage_c[NumCells].bad;

`ifndef SYNTHESIS
  // words in flight change only by what is taken in and handed out
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      $countones(valid_c[NumCells:1]) ==
        $countones($past(valid_c[NumCells:1])) + $past(in_i.valid && in_i.ready)
        - $past(out_o.valid && out_o.ready))
    else $error("cell chain occupancy out of step with handshakes");

  // the input stalls only when the first cell holds a word
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> valid_c[1])
    else $error("input stalled with first cell empty");

  // binary to bcd always yields decimal digits
  a_digits_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> all_digits_valid(out_o.bcd_out))
    else $error("non-decimal digit in bcd result");
`endif

endmodule

// File: bench/binary_bcd_converter_8digit_tb.sv
// ----------------------------------------------------------------------------
// binary_bcd_converter_8digit_tb: self-checking bench of the bcd converter
// drives request words from a queue, predicts each result word in the bench
// and checks every word on the result channel in order, under several idling
// mixes, a long result hold-off and a full drain between phases
// ----------------------------------------------------------------------------
module binary_bcd_converter_8digit_tb;
  import bbc_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 20;

  // one request word and one result word
  typedef struct packed {
    logic             operation;
    logic [WordW-1:0] binary_in;
    logic [WordW-1:0] bcd_in;
  } conv_word_t;

  typedef struct packed {
    logic [WordW-1:0] bcd_out;
    logic [SumW-1:0]  binary_out;
    logic             overflow;
    logic             invalid_digit;
  } conv_result_t;

  logic clk;
  logic rst_n;

  bbc_in_if  in_if ();
  bbc_out_if out_if ();

  conv_word_t   pending_words[$];
  conv_result_t expected_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned recv_holdoff_left;
  int unsigned idle_cycles;
  int unsigned error_count;
  int unsigned n_to_bcd;
  int unsigned n_to_bin;
  int unsigned n_overflow;
  int unsigned n_bad_nibble;

  binary_bcd_converter_8digit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // bit-exact prediction of one result word
  function automatic conv_result_t convert_word(conv_word_t w);
    conv_result_t     r;
    logic [WordW-1:0] rest;
    logic [WordW-1:0] weight;
    logic [WordW-1:0] sum;
    logic [NibW-1:0]  nib;
    r = '0;
    if (w.operation == OpToBcd) begin
      rest = w.binary_in % DecLimit;
      for (int k = 0; k < NumCells; k++) begin
        r.bcd_out[NibW*k +: NibW] = NibW'(rest % 10);
        rest = rest / 10;
      end
      r.overflow = (w.binary_in >= DecLimit);
    end else begin
      weight = 1;
      sum    = '0;
      for (int k = 0; k < NumCells; k++) begin
        nib = w.bcd_in[NibW*k +: NibW];
        if (nib > MaxDigit) begin
          r.invalid_digit = 1'b1;
        end
        sum    = sum + nib * weight;
        weight = weight * 10;
      end
      r.binary_out = sum[SumW-1:0];
    end
    return r;
  endfunction

  function automatic conv_word_t make_word(logic op, logic [31:0] bin, logic [31:0] bcd);
    conv_word_t w;
    w.operation = op;
    w.binary_in = bin;
    w.bcd_in    = bcd;
    return w;
  endfunction

  // random word: mostly in-range values and decimal digits, some out of range
  function automatic conv_word_t random_word();
    conv_word_t w;
    w.operation = 1'($urandom_range(1));
    w.binary_in = $urandom;
    w.bcd_in    = $urandom;
    case ($urandom_range(5))
      0:       w.binary_in = $urandom_range(99);
      1, 2:    w.binary_in = $urandom_range(32'd99999999);
      3:       w.binary_in = DecLimit - 32'd4 + $urandom_range(7);
      default: ;
    endcase
    case ($urandom_range(3))
      0, 1: begin
        for (int k = 0; k < NumCells; k++) w.bcd_in[NibW*k +: NibW] = NibW'($urandom_range(9));
      end
      2: begin
        for (int k = 0; k < NumCells; k++) w.bcd_in[NibW*k +: NibW] = NibW'($urandom_range(9));
        w.bcd_in[NibW*$urandom_range(NumCells-1) +: NibW] = NibW'($urandom_range(15, 10));
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%08h, want 0x%08h", $realtime, what, got, want);
    error_count++;
  endtask

  // wait until every queued word is sent and every result word has come
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_if.valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_phase(int unsigned n, int unsigned idle_pct, int unsigned stall_pct);
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) pending_words.push_back(random_word());
    wait_drained();
  endtask

  // request driver
  always @(posedge clk) begin
    conv_word_t w;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        w = make_word(in_if.operation, in_if.binary_in, in_if.bcd_in);
        expected_results.push_back(convert_word(w));
        if (w.operation == OpToBcd) begin
          n_to_bcd++;
          if (w.binary_in >= DecLimit) n_overflow++;
        end else begin
          n_to_bin++;
          if (!all_digits_valid(w.bcd_in)) n_bad_nibble++;
        end
      end
      if (in_if.valid && !in_if.ready) begin
        // word still on offer, hold it
      end else if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        in_if.valid     <= 1'b1;
        in_if.operation <= w.operation;
        in_if.binary_in <= w.binary_in;
        in_if.bcd_in    <= w.bcd_in;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result monitor and ready generation
  always @(posedge clk) begin
    conv_result_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word, bcd_out", out_if.bcd_out, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_if.bcd_out !== want.bcd_out)
            report_mismatch("bcd_out", out_if.bcd_out, want.bcd_out);
          if (out_if.binary_out !== want.binary_out)
            report_mismatch("binary_out", 32'(out_if.binary_out), 32'(want.binary_out));
          if (out_if.overflow !== want.overflow)
            report_mismatch("overflow", 32'(out_if.overflow), 32'(want.overflow));
          if (out_if.invalid_digit !== want.invalid_digit)
            report_mismatch("invalid_digit", 32'(out_if.invalid_digit),
                            32'(want.invalid_digit));
        end
      end
      if (recv_holdoff_left != 0) begin
        out_if.ready <= 1'b0;
        recv_holdoff_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus sequence
  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.operation   = OpToBcd;
    in_if.binary_in   = '0;
    in_if.bcd_in      = '0;
    out_if.ready      = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    recv_holdoff_left = 0;
    idle_cycles       = 0;
    error_count       = 0;
    n_to_bcd          = 0;
    n_to_bin          = 0;
    n_overflow        = 0;
    n_bad_nibble      = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed words: extremes, decimal limit, digit order, bad nibbles
    pending_words.push_back(make_word(OpToBcd, 32'd0, $urandom));
    pending_words.push_back(make_word(OpToBcd, 32'd1, $urandom));
    pending_words.push_back(make_word(OpToBcd, 32'd9, $urandom));
    pending_words.push_back(make_word(OpToBcd, 32'd10, $urandom));
    pending_words.push_back(make_word(OpToBcd, 32'd12345678, $urandom));
    pending_words.push_back(make_word(OpToBcd, 32'd99999999, $urandom));
    pending_words.push_back(make_word(OpToBcd, DecLimit, $urandom));
    pending_words.push_back(make_word(OpToBcd, 32'd100000001, $urandom));
    pending_words.push_back(make_word(OpToBcd, 32'h8000_0000, $urandom));
    pending_words.push_back(make_word(OpToBcd, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(OpToBin, $urandom, 32'h0000_0000));
    pending_words.push_back(make_word(OpToBin, $urandom, 32'h0000_0001));
    pending_words.push_back(make_word(OpToBin, $urandom, 32'h1234_5678));
    pending_words.push_back(make_word(OpToBin, $urandom, 32'h9999_9999));
    pending_words.push_back(make_word(OpToBin, $urandom, 32'h0909_0909));
    pending_words.push_back(make_word(OpToBin, $urandom, 32'h0000_000A));
    pending_words.push_back(make_word(OpToBin, $urandom, 32'hA000_0000));
    pending_words.push_back(make_word(OpToBin, $urandom, 32'hF0F0_F0F0));
    pending_words.push_back(make_word(OpToBin, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(OpToBin, 32'h0000_0000, 32'h0000_0000));
    wait_drained();

    // random phases with different idling mixes
    run_phase(100, 0, 0);

    // long result hold-off while the sender keeps offering words
    @(negedge clk);
    recv_holdoff_left = 60;
    run_phase(40, 0, 0);

    run_phase(100, 80, 0);
    run_phase(100, 0, 80);
    run_phase(120, 26, 26);

    // let any late word show up before the final verdict
    repeat (SettleCycles) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d result words never arrived", expected_results.size());
      error_count += expected_results.size();
    end

    $display("covered %0d binary-to-bcd words (%0d beyond eight digits), %0d bcd-to-binary",
             n_to_bcd, n_overflow, n_to_bin);
    $display("words (%0d with non-decimal nibbles) under mixed idling and back-pressure",
             n_bad_nibble);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bbc_pkg.sv
hw/rtl/bbc_if.sv
hw/rtl/bbc_cell.sv
hw/rtl/binary_bcd_converter_8digit.sv
bench/binary_bcd_converter_8digit_tb.sv
